// ----- hdl/rttwin_pkg.sv -----
// Shared types and constants for the RTT-driven AIMD congestion window block.
// Holds the flow state record, the window event codes and field widths.
// No dependencies.
`default_nettype none

package rttwin_pkg;

  localparam int WIN_W = 17;
  localparam int RTT_W = 32;
  localparam int RUN_W = 3;

  localparam logic [WIN_W-1:0] DEFAULT_WINDOW = 17'd64;
  localparam logic [WIN_W-1:0] WINDOW_LIMIT   = 17'h1FFFF;
  localparam logic [RUN_W-1:0] RUN_TARGET     = 3'd5;

  // Event code reported with every result
  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_IGNORED   = 2'd1,
    EV_HALVED    = 2'd2,
    EV_INCREASED = 2'd3
  } win_event_t;

  // Flow state carried from one sample to the next
  typedef struct packed {
    logic [RTT_W-1:0] rtt_average;
    logic [RTT_W-1:0] rtt_floor;
    logic             seen_sample;
    logic [WIN_W-1:0] window_now;
    logic [RUN_W-1:0] low_rtt_run;
  } flow_state_t;

  // Window loaded on restart: zero selects the default
  function automatic logic [WIN_W-1:0] restart_window(input logic [WIN_W-1:0] start);
    restart_window = (start != '0) ? start : DEFAULT_WINDOW;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rtt_ewma_aimd_window_core.sv -----
// RTT-driven AIMD congestion window core with an EWMA round trip estimate.
// Top level: input register, flow state, result register; uses rttwin_pkg
// and rttwin_update.
//
// Usage:
//   Sample channel: rtt_sample_us with sample_valid / sample_ready. A zero
//   sample leaves the flow state alone and reports event "ignored".
//   Result channel: cwnd_chunks, smoothed_rtt, baseline_rtt, window_event
//   with result_valid / result_ready; exactly one result per sample.
//   Config: pulse start_cwnd_we with start_cwnd to set the start
//   window (zero selects 64) and restart the flow; write only when idle.
// Timing:
//   A sample passes through the input register, then through the update logic
//   into the result register. Throughput is one sample per cycle while
//   result_ready does not stall; the state loop closes through the combinational
//   update logic (adds, compares and constant multiplies).
// Reset (synchronous, rst high): both stages empty, window 64, smoothed
//   RTT, baseline and run counter zero.
// Stall: while result_ready is low the result holds; one more sample may
//   wait in the input register, then sample_ready drops.
`default_nettype none

module rtt_ewma_aimd_window_core #(
  parameter int MAX_WINDOW = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start_cwnd_we,
  input  wire logic [16:0] start_cwnd,
  input  wire logic        sample_valid,
  output logic             sample_ready,
  input  wire logic [31:0] rtt_sample_us,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [16:0]      cwnd_chunks,
  output logic [31:0]      smoothed_rtt,
  output logic [31:0]      baseline_rtt,
  output logic [1:0]       window_event
);
  import rttwin_pkg::*;

  localparam logic [WIN_W-1:0] WINDOW_CAP =
    (MAX_WINDOW > int'(WINDOW_LIMIT)) ? WINDOW_LIMIT :
    (MAX_WINDOW < 1) ? 17'd1 : WIN_W'(MAX_WINDOW);

  logic             stage_valid;
  logic [RTT_W-1:0] stage_sample;
  logic             advance;
  flow_state_t      state;
  flow_state_t      state_next;
  win_event_t       event_next;

  assign advance      = stage_valid && (!result_valid || result_ready);
  assign sample_ready = !stage_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_ready) begin
      stage_valid <= sample_valid;
    end
    if (sample_valid && sample_ready) begin
      stage_sample <= rtt_sample_us;
    end
  end

  rttwin_update #(
    .WINDOW_CAP(WINDOW_CAP)
  ) u_update (
    .cur          (state),
    .rtt_sample_us(stage_sample),
    .nxt          (state_next),
    .win_event    (event_next)
  );

  // Flow state: restart on reset or config write, advance per sample
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{rtt_average: '0, rtt_floor: '0, seen_sample: 1'b0,
                 window_now: DEFAULT_WINDOW, low_rtt_run: '0};
    end else if (start_cwnd_we) begin
      state <= '{rtt_average: '0, rtt_floor: '0, seen_sample: 1'b0,
                 window_now: restart_window(start_cwnd), low_rtt_run: '0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || result_ready) begin
      result_valid <= stage_valid;
    end
    if (advance) begin
      cwnd_chunks  <= state_next.window_now;
      smoothed_rtt <= state_next.rtt_average;
      baseline_rtt <= state_next.rtt_floor;
      window_event <= event_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rttwin_update.sv -----
// Next-state logic for one RTT sample: EWMA update, baseline minimum and
// the AIMD window decision. Purely combinational; depends on rttwin_pkg.
`default_nettype none

module rttwin_update #(
  parameter logic [16:0] WINDOW_CAP = 17'd65536
) (
  input  wire rttwin_pkg::flow_state_t cur,
  input  wire logic [31:0]             rtt_sample_us,
  output rttwin_pkg::flow_state_t      nxt,
  output rttwin_pkg::win_event_t       win_event
);
  import rttwin_pkg::*;

  logic [RTT_W+2:0] ewma_acc;
  logic [RTT_W-1:0] avg_new;
  logic [RTT_W-1:0] floor_new;
  logic             above_double;
  logic             near_floor;
  logic [RTT_W+3:0] avg_x10;
  logic [RTT_W+3:0] floor_x11;
  logic [RUN_W-1:0] run_inc;
  logic [WIN_W-1:0] win_half;
  logic [WIN_W:0]   win_plus;

  // Smoothed RTT and baseline
  always_comb begin
    ewma_acc = {cur.rtt_average, 3'b000} - {3'b000, cur.rtt_average}
             + {3'b000, rtt_sample_us};
    if (!cur.seen_sample) begin
      avg_new   = rtt_sample_us;
      floor_new = rtt_sample_us;
    end else begin
      avg_new   = ewma_acc[RTT_W+2:3];
      floor_new = (avg_new < cur.rtt_floor) ? avg_new : cur.rtt_floor;
    end
  end

  // Ratio tests as exact cross-multiplications
  always_comb begin
    above_double = {1'b0, avg_new} > {floor_new, 1'b0};
    avg_x10      = {1'b0, avg_new, 3'b000} + {3'b000, avg_new, 1'b0};
    floor_x11    = {1'b0, floor_new, 3'b000} + {3'b000, floor_new, 1'b0}
                 + {4'b0000, floor_new};
    near_floor   = avg_x10 <= floor_x11;
  end

  // Window decrease and increase candidates
  always_comb begin
    run_inc  = cur.low_rtt_run + 3'd1;
    win_half = cur.window_now >> 1;
    if (win_half == '0) win_half = 17'd1;
    win_plus = {1'b0, cur.window_now} + 18'd1;
  end

  // Select next state and event
  always_comb begin
    nxt       = cur;
    win_event = EV_NONE;
    if (rtt_sample_us == '0) begin
      win_event = EV_IGNORED;
    end else begin
      nxt.rtt_average = avg_new;
      nxt.rtt_floor   = floor_new;
      nxt.seen_sample = 1'b1;
      if (floor_new != '0) begin
        if (above_double) begin
          nxt.window_now  = win_half;
          nxt.low_rtt_run = '0;
          win_event       = EV_HALVED;
        end else if (near_floor) begin
          nxt.low_rtt_run = run_inc;
          if (run_inc >= RUN_TARGET) begin
            nxt.window_now  = (win_plus > {1'b0, WINDOW_CAP}) ? WINDOW_CAP
                                                               : win_plus[WIN_W-1:0];
            nxt.low_rtt_run = '0;
            win_event       = EV_INCREASED;
          end
        end else begin
          nxt.low_rtt_run = '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rttwin_checker.sv -----
// Port-level checks for rtt_ewma_aimd_window_core, attached by bind.
// Depends on rttwin_pkg for the event codes.
`default_nettype none

module rttwin_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [16:0] cwnd_chunks,
  input wire logic [31:0] smoothed_rtt,
  input wire logic [31:0] baseline_rtt,
  input wire logic [1:0]  window_event
);
  import rttwin_pkg::*;

  // Window never collapses to zero
  a_window_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> cwnd_chunks != '0)
    else $error("cwnd_chunks is zero");

  // Baseline is the running minimum, so never above the smoothed value
  a_floor_below_avg: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> baseline_rtt <= smoothed_rtt)
    else $error("baseline_rtt above smoothed_rtt");

  // Halving only when smoothed exceeds twice the baseline
  a_halve_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid && window_event == EV_HALVED |->
      {1'b0, smoothed_rtt} > {baseline_rtt, 1'b0})
    else $error("halved without congestion");

  // Increase only within 1.1 of the baseline
  a_increase_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid && window_event == EV_INCREASED |->
      ({4'b0000, smoothed_rtt} * 36'd10) <= ({4'b0000, baseline_rtt} * 36'd11))
    else $error("increased while RTT high");

  // A stalled result holds its window
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(cwnd_chunks))
    else $error("stalled result changed");

endmodule

bind rtt_ewma_aimd_window_core rttwin_checker u_rttwin_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .cwnd_chunks (cwnd_chunks),
  .smoothed_rtt(smoothed_rtt),
  .baseline_rtt(baseline_rtt),
  .window_event(window_event)
);

`default_nettype wire

// ----- bench/rtt_ewma_aimd_window_core_test.sv -----
// Self-checking testbench for rtt_ewma_aimd_window_core: directed corner cases,
// a backpressure stall and random RTT flows, each result checked against a local model.
// Depends on rttwin_pkg and the rtt_ewma_aimd_window_core RTL.
module rtt_ewma_aimd_window_core_test;
  import rttwin_pkg::*;

  localparam int MAX_WINDOW     = 65536;
  localparam int WINDOW_CAP     = (MAX_WINDOW > WINDOW_LIMIT) ? WINDOW_LIMIT : MAX_WINDOW;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 60;
  localparam int RANDOM_PHASES  = 9;
  localparam int PHASE_ITEMS    = 100;

  typedef enum int {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PATTERN
  } ready_mode_t;

  typedef struct {
    logic [16:0] window;
    logic [31:0] smoothed;
    logic [31:0] baseline;
    win_event_t  kind;
  } window_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start_cwnd_we = 1'b0;
  logic [16:0] start_cwnd = '0;
  logic        sample_valid = 1'b0;
  logic        sample_ready;
  logic [31:0] rtt_sample_us = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [16:0] cwnd_chunks;
  logic [31:0] smoothed_rtt;
  logic [31:0] baseline_rtt;
  logic [1:0]  window_event;

  // Window model state and the results it predicts
  logic [16:0] start_window;
  logic [31:0] avg_rtt;
  logic [31:0] floor_rtt;
  logic        rtt_seen;
  logic [16:0] cwnd;
  logic [2:0]  calm_run;
  window_result_t window_results_q[$];

  // Sender and receiver pacing
  bit          sender_bursty = 1'b0;
  int          burst_left = 0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int          hold_request = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  bit          ready_level = 1'b0;
  int          ready_run = 0;

  int mismatch_count = 0;
  int results_checked = 0;
  int samples_sent = 0;
  int windows_loaded = 0;
  int kind_count[4] = '{0, 0, 0, 0};
  int stall_cycles = 0;

  rtt_ewma_aimd_window_core #(
    .MAX_WINDOW(MAX_WINDOW)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start_cwnd_we(start_cwnd_we),
    .start_cwnd(start_cwnd),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .rtt_sample_us(rtt_sample_us),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .cwnd_chunks(cwnd_chunks),
    .smoothed_rtt(smoothed_rtt),
    .baseline_rtt(baseline_rtt),
    .window_event(window_event)
  );

  always #10 clk = ~clk;

  // Reload the window and clear all RTT history
  function automatic void restart_flow_model();
    avg_rtt = '0;
    floor_rtt = '0;
    rtt_seen = 1'b0;
    calm_run = '0;
    cwnd = (start_window != '0) ? start_window : DEFAULT_WINDOW;
  endfunction

  // Advance the window model by one sample and queue the result it implies
  function automatic void advance_flow(input logic [31:0] sample);
    logic [63:0]    acc;
    logic [17:0]    grown;
    window_result_t r;
    r.kind = EV_NONE;
    if (sample == '0) begin
      r.kind = EV_IGNORED;
    end else begin
      if (!rtt_seen) begin
        avg_rtt = sample;
        floor_rtt = sample;
        rtt_seen = 1'b1;
      end else begin
        acc = 64'(avg_rtt) * 64'd7 + 64'(sample);
        avg_rtt = acc[34:3];
        if (avg_rtt < floor_rtt) floor_rtt = avg_rtt;
      end
      if (floor_rtt != '0) begin
        if (64'(avg_rtt) > 64'(floor_rtt) * 64'd2) begin
          // congestion: halve, never below one chunk
          cwnd = (cwnd > 17'd1) ? (cwnd >> 1) : 17'd1;
          calm_run = '0;
          r.kind = EV_HALVED;
        end else if (64'(avg_rtt) * 64'd10 <= 64'(floor_rtt) * 64'd11) begin
          calm_run = calm_run + 3'd1;
          if (calm_run >= RUN_TARGET) begin
            grown = 18'(cwnd) + 18'd1;
            cwnd = (grown > 18'(WINDOW_CAP)) ? 17'(WINDOW_CAP) : grown[16:0];
            calm_run = '0;
            r.kind = EV_INCREASED;
          end
        end else begin
          calm_run = '0;
        end
      end
    end
    r.window = cwnd;
    r.smoothed = avg_rtt;
    r.baseline = floor_rtt;
    window_results_q.push_back(r);
  endfunction

  // Offer one sample and hold it until the transaction completes
  task automatic send_sample(input logic [31:0] sample);
    sample_valid <= 1'b1;
    rtt_sample_us <= sample;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    advance_flow(sample);
    samples_sent++;
  endtask

  // Send with random bursts and gaps when the sender is bursty
  task automatic offer_sample(input logic [31:0] sample);
    int unsigned gap;
    if (sender_bursty && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    send_sample(sample);
  endtask

  // Drain the pipeline, then write the start window and restart the model
  task automatic load_start_window(input logic [16:0] value);
    sample_valid <= 1'b0;
    while (window_results_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    start_cwnd_we <= 1'b1;
    start_cwnd <= value;
    @(posedge clk);
    start_cwnd_we <= 1'b0;
    start_window = value;
    restart_flow_model();
    windows_loaded++;
  endtask

  function automatic logic [31:0] pick_base();
    int unsigned shift;
    shift = $urandom_range(0, 27);
    return $urandom_range(16, 32'hFFFF_FFFF >> shift);
  endfunction

  // Mostly samples close to the current level, with spikes, rises, zeros and noise
  function automatic logic [31:0] next_sample(input logic [31:0] base);
    logic [35:0] v;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) v = '0;
    else if (pick < 7) v = 36'($urandom());
    else if (pick < 11) v = 36'(base) * 36'($urandom_range(3, 9));
    else if (pick < 18) v = 36'(base) + 36'(base / 4) + 36'($urandom_range(0, base / 8));
    else v = 36'(base) + 36'($urandom_range(0, base / 24));
    return (v > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // Zero before any sample, first sample, growth after a calm run, halving
  task automatic test_first_samples_and_growth();
    send_sample(32'd0);
    repeat (5) send_sample(32'd1000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'd0);
  endtask

  task automatic test_halve_at_minimum();
    load_start_window(17'd1);
    send_sample(32'd1);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'd1);
  endtask

  task automatic test_increase_at_cap();
    load_start_window(17'(WINDOW_CAP));
    repeat (5) send_sample(32'hFFFF_FFFF);
  endtask

  task automatic test_window_above_cap();
    load_start_window(WINDOW_LIMIT);
    repeat (5) send_sample(32'd1);
  endtask

  // Zero start window selects the default; then a moderate rise and a zero
  task automatic test_zero_start_window();
    load_start_window(17'd0);
    send_sample(32'd800);
    send_sample(32'd2000);
    send_sample(32'd0);
  endtask

  // Hold the result side off for a long stretch while samples keep coming
  task automatic test_result_backpressure();
    ready_mode <= READY_ALWAYS;
    sender_bursty = 1'b0;
    hold_request <= hold_request + 1;
    for (int n = 0; n < 24; n++) send_sample(32'd5000 + $urandom_range(0, 200));
  endtask

  task automatic test_random_flows();
    logic [16:0] settings[RANDOM_PHASES];
    logic [31:0] base;
    settings = '{17'd0, 17'd1, 17'd2, DEFAULT_WINDOW, 17'h0FFFF, 17'h10000, 17'h10001,
                 WINDOW_LIMIT, 17'd0};
    settings[RANDOM_PHASES-1] = 17'($urandom_range(0, 17'h1FFFF));
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_start_window(settings[phase]);
      ready_mode <= ready_mode_t'(phase % 3);
      sender_bursty = (phase % 4 != 3);
      base = pick_base();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // let the path drift down now and then so the baseline moves
        if ($urandom_range(0, 99) < 3 && base > 32'd8) base = base - base / 8;
        offer_sample(next_sample(base));
      end
    end
  endtask

  // Receiver: long hold on request, otherwise the current stall pattern
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (hold_served != hold_request) begin
      hold_served = hold_request;
      hold_left = HOLD_CYCLES - 1;
      result_ready <= 1'b0;
    end else begin
      case (ready_mode)
        READY_ALWAYS: result_ready <= 1'b1;
        READY_RANDOM: result_ready <= ($urandom_range(0, 99) >= 35);
        default: begin
          if (ready_run == 0) begin
            ready_level = !ready_level;
            ready_run = ready_level ? $urandom_range(1, 8) : $urandom_range(1, 5);
          end
          ready_run--;
          result_ready <= ready_level;
        end
      endcase
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    window_result_t exp_r;
    if (!rst && result_valid && result_ready) begin
      if (window_results_q.size() == 0) begin
        $display("%0t: unexpected result: window %0d smoothed %0d baseline %0d event %0d",
                 $time, cwnd_chunks, smoothed_rtt, baseline_rtt, window_event);
        mismatch_count++;
      end else begin
        exp_r = window_results_q.pop_front();
        results_checked++;
        kind_count[exp_r.kind]++;
        if (cwnd_chunks !== exp_r.window) begin
          $display("%0t: cwnd_chunks expected %0d actual %0d",
                   $time, exp_r.window, cwnd_chunks);
          mismatch_count++;
        end
        if (smoothed_rtt !== exp_r.smoothed) begin
          $display("%0t: smoothed_rtt expected %0d actual %0d",
                   $time, exp_r.smoothed, smoothed_rtt);
          mismatch_count++;
        end
        if (baseline_rtt !== exp_r.baseline) begin
          $display("%0t: baseline_rtt expected %0d actual %0d",
                   $time, exp_r.baseline, baseline_rtt);
          mismatch_count++;
        end
        if (window_event !== exp_r.kind) begin
          $display("%0t: window_event expected %0d actual %0d",
                   $time, exp_r.kind, window_event);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((sample_valid && sample_ready) || (result_valid && result_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    start_window = DEFAULT_WINDOW;
    restart_flow_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_first_samples_and_growth();
    test_halve_at_minimum();
    test_increase_at_cap();
    test_window_above_cap();
    test_zero_start_window();
    test_result_backpressure();
    test_random_flows();
    sample_valid <= 1'b0;
    while (window_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Checked %0d results from %0d samples across %0d start window writes",
             results_checked, samples_sent, windows_loaded);
    $display("Events: %0d unchanged, %0d ignored, %0d halved, %0d increased; %0d mismatches",
             kind_count[EV_NONE], kind_count[EV_IGNORED], kind_count[EV_HALVED],
             kind_count[EV_INCREASED], mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
